[rtl/multi_jitter_pattern_builder_macros.svh]
// Assertion macros used by the pattern builder datapath.
`ifndef MULTI_JITTER_PATTERN_BUILDER_MACROS_SVH
`define MULTI_JITTER_PATTERN_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MJP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MJP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mjp_pkg.sv]
// Package with the types, constants and codes of the pattern builder.
`default_nettype none
package mjp_pkg;

  localparam int MAX_GRID_LOG2_DEF = 4;
  localparam int CFG_W = 3;
  localparam int FRAC_W = 16;
  localparam int IDX_W = 8;
  localparam logic [CFG_W-1:0] GRID_LOG2_RESET = 3'd2;
  localparam int RAM_WIDTH_DEF = 16;
  localparam int RAM_DEPTH_DEF = 256;

  localparam logic KIND_FRACTION = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic kind;
    logic [FRAC_W-1:0] random_fraction;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0] sample_u;
    logic [FRAC_W-1:0] sample_v;
    logic pattern_ready;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_SWAP_RD,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_READ,
    ST_READ_WAIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic cfg_write;
    logic gen_write;
    logic swap_read;
    logic swap_write_a;
    logic swap_write_b;
    logic read_issue;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic shuffle;
    logic result_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/mjp_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module mjp_ram
  import mjp_pkg::*;
#(
  parameter int WIDTH = RAM_WIDTH_DEF,
  parameter int DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

[rtl/mjp_ctrl.sv]
// Controller state machine that sequences item handling and store accesses.
`default_nettype none
module mjp_ctrl
  import mjp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic    item_kind,
  input  wire logic    cfg_valid,
  input  wire status_t sts,
  output logic         item_ready,
  output logic         cfg_ready,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cfg_valid && item_valid) begin
          if (item_kind == KIND_READ) begin
            state_next = ST_READ;
          end else if (sts.shuffle) begin
            state_next = ST_SWAP_RD;
          end else begin
            state_next = ST_GEN;
          end
        end
      end
      ST_GEN:       state_next = ST_IDLE;
      ST_SWAP_RD:   state_next = ST_SWAP_WA;
      ST_SWAP_WA:   state_next = ST_SWAP_WB;
      ST_SWAP_WB:   state_next = ST_IDLE;
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: begin
        if (sts.result_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    item_ready = 1'b0;
    cfg_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        item_ready = !cfg_valid;
        cmd.cfg_write = cfg_valid;
        cmd.latch = item_valid && !cfg_valid;
      end
      ST_GEN:       cmd.gen_write = 1'b1;
      ST_SWAP_RD:   cmd.swap_read = 1'b1;
      ST_SWAP_WA:   cmd.swap_write_a = 1'b1;
      ST_SWAP_WB:   cmd.swap_write_b = 1'b1;
      ST_READ:      cmd.read_issue = 1'b1;
      ST_READ_WAIT: cmd.result_load = sts.result_free;
      default:      cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/mjp_datapath.sv]
// Datapath with the counters, the address and value arithmetic, the stores and the result register.
`default_nettype none
module mjp_datapath
  import mjp_pkg::*;
#(
  parameter int MAX_GRID_LOG2 = MAX_GRID_LOG2_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  input  wire in_item_t         item,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             result_ready,
  output status_t               sts,
  output out_item_t             result,
  output logic                  result_valid
);

  `include "multi_jitter_pattern_builder_macros.svh"

  localparam int LW = MAX_GRID_LOG2;
  localparam int AW = 2 * MAX_GRID_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int GW = $clog2(MAX_GRID_LOG2 + 1);
  localparam int NW = MAX_GRID_LOG2 + 1;
  localparam int PW = FRAC_W + NW;

  logic [CFG_W-1:0] grid_cfg;
  in_item_t         item_q;
  logic             phase;
  logic [LW-1:0]    row;
  logic [LW-1:0]    col;
  logic             second;
  logic             ready_flag;

  logic [GW-1:0]    eff;
  logic [NW-1:0]    n;
  logic [NW-1:0]    n_minus_1;
  logic [NW-1:0]    n_minus_j;
  logic [PW-1:0]    prod;
  logic [NW-1:0]    k_sum;
  logic [LW-1:0]    k;
  logic [AW-1:0]    cell_ij;
  logic [AW-1:0]    cell_ji;
  logic [AW-1:0]    cell_ik;
  logic [AW-1:0]    cell_ki;
  logic [AW-1:0]    gen_cell;
  logic [AW+FRAC_W-1:0] gen_shift;
  logic [FRAC_W-1:0] gen_val;
  logic [AW-1:0]    idx_mask;
  logic [AW-1:0]    swap_a;
  logic [AW-1:0]    swap_b;

  logic             re;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic             u_we;
  logic             v_we;
  logic [AW-1:0]    waddr;
  logic [FRAC_W-1:0] wdata;
  logic [FRAC_W-1:0] u_rdata_a;
  logic [FRAC_W-1:0] u_rdata_b;
  logic [FRAC_W-1:0] v_rdata_a;
  logic [FRAC_W-1:0] v_rdata_b;
  logic             advance;

  always_comb begin
    if (grid_cfg > CFG_W'(MAX_GRID_LOG2)) begin
      eff = GW'(MAX_GRID_LOG2);
    end else begin
      eff = grid_cfg[GW-1:0];
    end
  end

  assign n = NW'(1) << eff;
  assign n_minus_1 = n - NW'(1);
  assign n_minus_j = n - NW'(col);
  assign prod = PW'(item_q.random_fraction) * PW'(n_minus_j);
  assign k_sum = NW'(col) + prod[PW-1:FRAC_W];
  assign k = k_sum[LW-1:0];

  assign cell_ij = (AW'(row) << eff) | AW'(col);
  assign cell_ji = (AW'(col) << eff) | AW'(row);
  assign cell_ik = (AW'(row) << eff) | AW'(k);
  assign cell_ki = (AW'(k) << eff) | AW'(row);

  assign gen_cell = second ? cell_ji : cell_ij;
  assign gen_shift = {gen_cell, item_q.random_fraction} >> {eff, 1'b0};
  assign gen_val = gen_shift[FRAC_W-1:0];

  assign idx_mask = (AW'(1) << {eff, 1'b0}) - AW'(1);
  assign swap_a = second ? cell_ji : cell_ij;
  assign swap_b = second ? cell_ki : cell_ik;

  always_comb begin
    re = cmd.read_issue || cmd.swap_read;
    raddr_a = cmd.read_issue ? (AW'(item_q.read_index) & idx_mask) : swap_a;
    raddr_b = swap_b;
    u_we = 1'b0;
    v_we = 1'b0;
    waddr = cell_ij;
    wdata = gen_val;
    if (cmd.gen_write) begin
      u_we = !second;
      v_we = second;
    end else if (cmd.swap_write_a) begin
      u_we = !second;
      v_we = second;
      waddr = swap_a;
      wdata = second ? v_rdata_b : u_rdata_b;
    end else if (cmd.swap_write_b) begin
      u_we = !second;
      v_we = second;
      waddr = swap_b;
      wdata = second ? v_rdata_a : u_rdata_a;
    end
  end

  assign advance = (cmd.gen_write || cmd.swap_write_b) && second;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cfg <= GRID_LOG2_RESET;
      phase <= 1'b0;
      row <= '0;
      col <= '0;
      second <= 1'b0;
      ready_flag <= 1'b0;
    end else if (cmd.cfg_write) begin
      grid_cfg <= cfg_data;
      phase <= 1'b0;
      row <= '0;
      col <= '0;
      second <= 1'b0;
      ready_flag <= 1'b0;
    end else if (cmd.latch && item.kind == KIND_FRACTION && ready_flag) begin
      phase <= 1'b0;
      row <= '0;
      col <= '0;
      second <= 1'b0;
      ready_flag <= 1'b0;
    end else if (cmd.gen_write || cmd.swap_write_b) begin
      second <= !second;
      if (advance) begin
        if (col == n_minus_1[LW-1:0]) begin
          col <= '0;
          if (row == n_minus_1[LW-1:0]) begin
            row <= '0;
            if (phase) begin
              phase <= 1'b0;
              ready_flag <= 1'b1;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            row <= row + LW'(1);
          end
        end else begin
          col <= col + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result.sample_u <= u_rdata_a;
      result.sample_v <= v_rdata_a;
      result.pattern_ready <= ready_flag;
    end
  end

  assign sts.shuffle = phase && !ready_flag;
  assign sts.result_free = !result_valid || result_ready;

  mjp_ram #(
    .WIDTH(FRAC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (u_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (u_rdata_a),
    .rdata_b (u_rdata_b)
  );

  mjp_ram #(
    .WIDTH(FRAC_W),
    .DEPTH(DEPTH)
  ) v_store (
    .clk     (clk),
    .we      (v_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (v_rdata_a),
    .rdata_b (v_rdata_b)
  );

  `MJP_ASSERT_SAME(a_load_free, cmd.result_load, !result_valid || result_ready, "result overwritten")
  `MJP_ASSERT_SAME(a_count_range, 1'b1, NW'(row) <= n_minus_1 && NW'(col) <= n_minus_1, "count out of grid")
  `MJP_ASSERT_SAME(a_ready_rise, $rose(ready_flag), $past(cmd.swap_write_b), "ready flag set outside shuffle end")

endmodule
`default_nettype wire

[rtl/multi_jitter_pattern_builder.sv]
// Top level of the multi-jittered pattern builder: controller, datapath and ports.
//
//   channel | direction | payload
//   item    | in        | in_item_t: kind, random_fraction, read_index
//   result  | out       | out_item_t: sample_u, sample_v, pattern_ready
//   cfg     | in        | grid_side_log2, three bits
//
// A fraction item runs ST_GEN in generation and the ST_SWAP states in the shuffle pass.
// A read item runs ST_READ, then waits in ST_READ_WAIT until the result register is free.
// The shuffle swap is bound by the single write port of each store: two writes, one per cycle.
// Reset is synchronous and leaves the stores unwritten; no clearing pass is run.
// One finished result may wait in the output register while the next item is taken.
`default_nettype none
module multi_jitter_pattern_builder
  import mjp_pkg::*;
#(
  parameter int MAX_GRID_LOG2 = MAX_GRID_LOG2_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire in_item_t         item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output out_item_t             result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  mjp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .cfg_valid  (cfg_valid),
    .sts        (sts),
    .item_ready (item_ready),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  mjp_datapath #(
    .MAX_GRID_LOG2(MAX_GRID_LOG2)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

[tb/mjp_checker.sv]
// Checker for the pattern builder: follows all three channels, predicts every read and compares.
module mjp_checker
  import mjp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_ready,
  input  in_item_t                 item,
  input  logic                     result_valid,
  input  logic                     result_ready,
  input  out_item_t                result,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending,
  output logic [RAM_DEPTH_DEF-1:0] filled
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FRAC_W-1:0]        u_model [RAM_DEPTH_DEF];
  logic [FRAC_W-1:0]        v_model [RAM_DEPTH_DEF];
  logic [RAM_DEPTH_DEF-1:0] u_known;
  logic [RAM_DEPTH_DEF-1:0] v_known;
  logic [CFG_W-1:0]         grid_reg = GRID_LOG2_RESET;
  logic                     shuffling;
  logic                     v_turn;
  logic                     complete;
  int unsigned              row;
  int unsigned              col;
  out_item_t                expected_samples [$];
  int                       mismatches = 0;

  assign fail_count = mismatches;

  function automatic int unsigned grid_log2_eff();
    return (grid_reg > MAX_GRID_LOG2_DEF) ? MAX_GRID_LOG2_DEF : int'(grid_reg);
  endfunction

  task automatic restart_walk();
    shuffling = 1'b0;
    v_turn    = 1'b0;
    complete  = 1'b0;
    row       = 0;
    col       = 0;
  endtask

  task automatic step_cell(input int unsigned n);
    col++;
    if (col >= n) begin
      col = 0;
      row++;
      if (row >= n) begin
        row = 0;
        if (!shuffling) begin
          shuffling = 1'b1;
        end else begin
          shuffling = 1'b0;
          complete  = 1'b1;
        end
      end
    end
  endtask

  task automatic take_fraction(input logic [FRAC_W-1:0] r);
    int unsigned       g;
    int unsigned       n;
    int unsigned       mask;
    int unsigned       i;
    int unsigned       j;
    int unsigned       k;
    int unsigned       a;
    int unsigned       b;
    logic [31:0]       cell_no;
    logic [FRAC_W-1:0] t;
    g    = grid_log2_eff();
    n    = 1 << g;
    mask = n * n - 1;
    i    = row & (n - 1);
    j    = col & (n - 1);
    if (complete) begin
      restart_walk();
      i = 0;
      j = 0;
    end
    if (!shuffling) begin
      a = (i * n + j) & mask;
      if (!v_turn) begin
        cell_no    = i * n + j;
        u_model[a] = 16'(((cell_no << 16) + r) >> (2 * g));
        u_known[a] = 1'b1;
        v_turn     = 1'b1;
      end else begin
        cell_no    = j * n + i;
        v_model[a] = 16'(((cell_no << 16) + r) >> (2 * g));
        v_known[a] = 1'b1;
        v_turn     = 1'b0;
        step_cell(n);
      end
    end else begin
      k = j + ((32'(r) * (n - j)) >> 16);
      if (k > n - 1) begin
        k = n - 1;
      end
      if (!v_turn) begin
        a          = (i * n + j) & mask;
        b          = (i * n + k) & mask;
        t          = u_model[a];
        u_model[a] = u_model[b];
        u_model[b] = t;
        v_turn     = 1'b1;
      end else begin
        a          = (j * n + i) & mask;
        b          = (k * n + i) & mask;
        t          = v_model[a];
        v_model[a] = v_model[b];
        v_model[b] = t;
        v_turn     = 1'b0;
        step_cell(n);
      end
    end
  endtask

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected u=%h v=%h ready=%b, got u=%h v=%h ready=%b", $realtime, what,
               want.sample_u, want.sample_v, want.pattern_ready,
               got.sample_u, got.sample_v, got.pattern_ready);
    end
  endtask

  always @(posedge clk) begin
    out_item_t   want;
    int unsigned mask;
    if (rst) begin
      grid_reg = GRID_LOG2_RESET;
      restart_walk();
      u_known = '0;
      v_known = '0;
      expected_samples.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_samples.size() == 0) begin
          note_failure("unexpected result", '0, result);
        end else begin
          want = expected_samples.pop_front();
          if (result.sample_u !== want.sample_u || result.sample_v !== want.sample_v ||
              result.pattern_ready !== want.pattern_ready) begin
            note_failure("sample mismatch", want, result);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        grid_reg = cfg_data;
        restart_walk();
      end
      if (item_valid && item_ready) begin
        if (item.kind == KIND_FRACTION) begin
          take_fraction(item.random_fraction);
        end else begin
          mask               = (1 << (2 * grid_log2_eff())) - 1;
          want.sample_u      = u_model[item.read_index & mask];
          want.sample_v      = v_model[item.read_index & mask];
          want.pattern_ready = complete;
          expected_samples.push_back(want);
        end
      end
    end
    pending <= expected_samples.size();
    filled  <= u_known & v_known;
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the pattern builder: clock, reset, stimulus, handshake pacing and verdict.
module tb_top;
  import mjp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 180;
  localparam int BURST_READS   = 30;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_ready;
  in_item_t                 item = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  out_item_t                result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;
  int                       fail_count;
  int                       pending;
  logic [RAM_DEPTH_DEF-1:0] filled;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          sent = 0;
  int          cycle_count = 0;
  int unsigned grid_log2 = GRID_LOG2_RESET;

  multi_jitter_pattern_builder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  mjp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .filled       (filled)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned grid_eff(input int unsigned v);
    return (v > MAX_GRID_LOG2_DEF) ? MAX_GRID_LOG2_DEF : v;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_grid();
    case ($urandom_range(19))
      0, 1, 2, 3:      return 0;
      4, 5, 6, 7, 8:   return 1;
      9, 10, 11, 12:   return 2;
      13, 14, 15, 16:  return 3;
      17:              return 4;
      18:              return $urandom_range(5, 7);
      default:         return 7;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_fraction(input logic [FRAC_W-1:0] r);
    in_item_t it;
    it.kind            = KIND_FRACTION;
    it.random_fraction = r;
    it.read_index      = IDX_W'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.kind            = KIND_READ;
    it.random_fraction = FRAC_W'($urandom);
    it.read_index      = idx;
    send_item(it);
  endtask

  // Only entries whose U and V have both been written are ever read.
  task automatic pick_read_index(output bit ok, output logic [IDX_W-1:0] idx);
    int unsigned eg;
    int unsigned mask;
    int unsigned first;
    int unsigned c;
    int unsigned s;
    eg    = grid_eff(grid_log2);
    mask  = (1 << (2 * eg)) - 1;
    first = $urandom_range(mask);
    ok    = 1'b0;
    idx   = '0;
    for (s = 0; s <= mask && !ok; s++) begin
      c = (first + s) & mask;
      if (filled[c]) begin
        idx = IDX_W'(c | ($urandom << (2 * eg)));
        ok  = 1'b1;
      end
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_grid(input int unsigned v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(v);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    grid_log2 = v;
  endtask

  task automatic read_or_fraction();
    bit               ok;
    logic [IDX_W-1:0] idx;
    pick_read_index(ok, idx);
    if (ok) begin
      send_read(idx);
    end else begin
      send_fraction(pick_fraction());
    end
  endtask

  task automatic run_pattern(input int unsigned gv);
    int unsigned eg;
    int unsigned full;
    int unsigned left;
    write_grid(gv);
    eg   = grid_eff(gv);
    full = 4 << (2 * eg);
    if (eg >= MAX_GRID_LOG2_DEF) begin
      left = $urandom_range(64, 640);
    end else begin
      case ($urandom_range(9))
        0, 1:    left = $urandom_range(1, full - 1);
        2:       left = 2 * full + $urandom_range(0, full / 2);
        default: left = full;
      endcase
    end
    while (left > 0) begin
      if ($urandom_range(3) == 0) begin
        read_or_fraction();
      end else begin
        send_fraction(pick_fraction());
        left--;
      end
    end
    repeat ($urandom_range(2, 6)) read_or_fraction();
  endtask

  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_start;
    bit first_pattern;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-cell grid: reads before and after completion, then a restart by a new fraction.
    write_grid(0);
    send_fraction(16'h0000);
    send_fraction(16'hFFFF);
    send_read(8'hFF);
    send_fraction(16'hFFFF);
    send_fraction(16'h0000);
    send_read(8'h00);
    send_read(8'hA5);
    send_fraction(16'h8000);
    send_read(8'h5A);
    // An oversized grid setting saturates to the largest grid.
    write_grid(7);
    send_fraction(16'hFFFF);
    send_fraction(16'h0000);
    send_read(8'h00);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start   = sent;
      first_pattern = 1'b1;
      while (sent - phase_start < PHASE_ITEMS) begin
        run_pattern(pick_grid());
        if (first_pattern) begin
          first_pattern = 1'b0;
          hold_requests <= hold_requests + 1;
          repeat (BURST_READS) read_or_fraction();
          drain();
        end
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[multi_jitter_pattern_builder.f]
+incdir+rtl
rtl/mjp_pkg.sv
rtl/mjp_ram.sv
rtl/mjp_ctrl.sv
rtl/mjp_datapath.sv
rtl/multi_jitter_pattern_builder.sv
tb/mjp_checker.sv
tb/tb_top.sv
